// ===== rtl/modular_inverse_euclid_assert.svh =====
// Assertion macros used by the modular inverse controller.
`ifndef MODULAR_INVERSE_EUCLID_ASSERT_SVH
`define MODULAR_INVERSE_EUCLID_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MIE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is held.
`define MIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/mie_pkg.sv =====
// Package with the item types, widths and control structures of the modular inverse.
package mie_pkg;

  localparam int WORD_BITS  = 32;
  localparam int SHIFT_BITS = $clog2(WORD_BITS);

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic [WORD_BITS-1:0] modulus;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] inverse;
    logic                 no_inverse;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic align;
    logic sub;
    logic swap;
    logic count;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic div_zero;
    logic align_ok;
    logic sh_zero;
    logic rem_zero;
  } dp_stat_t;

endpackage

// ===== rtl/mie_dpath.sv =====
// Datapath of the modular inverse: shift-subtract divider with coefficient accumulation.
module mie_dpath (
  input  logic               clk,
  input  mie_pkg::in_item_t  in_data,
  input  mie_pkg::dp_cmd_t   cmd,
  output mie_pkg::dp_stat_t  stat,
  output mie_pkg::out_item_t out_data
);
  import mie_pkg::*;

  logic [WORD_BITS-1:0]  m_r,  m_nxt;
  logic [WORD_BITS-1:0]  rp_r, rp_nxt;
  logic [WORD_BITS-1:0]  rc_r, rc_nxt;
  logic [WORD_BITS-1:0]  d_r,  d_nxt;
  logic [WORD_BITS-1:0]  cp_r, cp_nxt;
  logic [WORD_BITS-1:0]  cc_r, cc_nxt;
  logic [WORD_BITS-1:0]  cd_r, cd_nxt;
  logic [SHIFT_BITS-1:0] sh_r, sh_nxt;
  logic                  neg_r, neg_nxt;
  logic                  adv_r, adv_nxt;
  out_item_t             out_r, out_nxt;
  logic [WORD_BITS-1:0]  mag;
  logic                  ge;

  assign ge = (rp_r >= d_r);
  assign mag = (cp_r >= m_r) ? (cp_r - m_r) : cp_r;

  assign stat.div_zero = (d_r == '0);
  assign stat.align_ok = ({d_r, 1'b0} <= {1'b0, rp_r});
  assign stat.sh_zero  = (sh_r == '0);
  assign stat.rem_zero = (rp_r == '0);

  always_comb begin
    m_nxt   = m_r;
    rp_nxt  = rp_r;
    rc_nxt  = rc_r;
    d_nxt   = d_r;
    cp_nxt  = cp_r;
    cc_nxt  = cc_r;
    cd_nxt  = cd_r;
    sh_nxt  = sh_r;
    neg_nxt = neg_r;
    adv_nxt = adv_r;
    out_nxt = out_r;
    if (cmd.load) begin
      m_nxt   = in_data.modulus;
      rp_nxt  = in_data.value;
      rc_nxt  = in_data.modulus;
      d_nxt   = in_data.modulus;
      cp_nxt  = {{(WORD_BITS-1){1'b0}}, 1'b1};
      cc_nxt  = '0;
      cd_nxt  = '0;
      sh_nxt  = '0;
      neg_nxt = 1'b0;
      adv_nxt = 1'b0;
    end else if (cmd.align) begin
      d_nxt  = {d_r[WORD_BITS-2:0], 1'b0};
      cd_nxt = {cd_r[WORD_BITS-2:0], 1'b0};
      sh_nxt = sh_r + 1'b1;
    end else if (cmd.sub) begin
      if (ge) begin
        rp_nxt = rp_r - d_r;
        cp_nxt = cp_r + cd_r;
      end
      d_nxt  = {1'b0, d_r[WORD_BITS-1:1]};
      cd_nxt = {1'b0, cd_r[WORD_BITS-1:1]};
      sh_nxt = sh_r - 1'b1;
    end else if (cmd.swap) begin
      rp_nxt = rc_r;
      rc_nxt = rp_r;
      d_nxt  = rp_r;
      cp_nxt = cc_r;
      cc_nxt = cp_r;
      cd_nxt = cp_r;
      sh_nxt = '0;
      if (cmd.count) begin
        neg_nxt = adv_r ? ~neg_r : 1'b0;
        adv_nxt = 1'b1;
      end
    end else if (cmd.fin) begin
      out_nxt.inverse    = '0;
      out_nxt.no_inverse = 1'b1;
      if (m_r == {{(WORD_BITS-1){1'b0}}, 1'b1}) begin
        out_nxt.no_inverse = 1'b0;
      end else if (m_r != '0 && adv_r && rp_r == {{(WORD_BITS-1){1'b0}}, 1'b1}) begin
        out_nxt.no_inverse = 1'b0;
        out_nxt.inverse    = (neg_r && mag != '0) ? (m_r - mag) : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    rp_r  <= rp_nxt;
    rc_r  <= rc_nxt;
    d_r   <= d_nxt;
    cp_r  <= cp_nxt;
    cc_r  <= cc_nxt;
    cd_r  <= cd_nxt;
    sh_r  <= sh_nxt;
    neg_r <= neg_nxt;
    adv_r <= adv_nxt;
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ===== rtl/mie_ctrl.sv =====
// Controller of the modular inverse: sequences reduction, Euclid steps and the result.
`include "modular_inverse_euclid_assert.svh"
module mie_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mie_pkg::dp_stat_t stat,
  output mie_pkg::dp_cmd_t  cmd
);
  import mie_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALIGN = 3'd1;
  localparam logic [2:0] S_SUB   = 3'd2;
  localparam logic [2:0] S_SWAP  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       red_r, red_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    red_nxt   = red_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          red_nxt   = 1'b1;
          state_nxt = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (stat.div_zero) begin
          state_nxt = S_FIN;
        end else if (stat.align_ok) begin
          cmd.align = 1'b1;
        end else begin
          cmd.sub   = 1'b1;
          state_nxt = stat.sh_zero ? S_SWAP : S_SUB;
        end
      end
      S_SUB: begin
        cmd.sub = 1'b1;
        if (stat.sh_zero) begin
          state_nxt = S_SWAP;
        end
      end
      S_SWAP: begin
        cmd.swap  = 1'b1;
        cmd.count = ~red_r;
        red_nxt   = 1'b0;
        state_nxt = stat.rem_zero ? S_FIN : S_ALIGN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      red_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      red_r       <= red_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MIE_ASSERT_NEXT(a_sub_ends_in_swap, clk, rst_n, state_r == S_SUB && stat.sh_zero, state_r == S_SWAP)
  `MIE_ASSERT_NEXT(a_zero_divisor_to_fin, clk, rst_n, state_r == S_ALIGN && stat.div_zero, state_r == S_FIN)
  `MIE_ASSERT_NEXT(a_fin_sets_valid, clk, rst_n, cmd.fin, out_valid_r && state_r == S_IDLE)

endmodule

// ===== rtl/modular_inverse_euclid.sv =====
// Top level of the modular inverse by the extended Euclidean algorithm.
// Each division, including the initial reduction, shifts the divisor up to align it and then
// shifts it back down, subtracting where it fits; a zero modulus goes straight to the result.
// Items are taken only in idle, one at a time; the next item is taken while the result waits.
// Reset (rst_n, synchronous, active low) returns the controller to idle with no result held.
module modular_inverse_euclid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mie_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mie_pkg::out_item_t out_data
);
  import mie_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mie_dpath u_dpath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
